/* rtl/csp_pkg.sv */
`timescale 1ns / 1ps

package csp_pkg;

  localparam int COORD_BITS      = 16;
  localparam int PARAM_FRAC_BITS = 15;
  localparam int GUARD_BITS      = 8;
  localparam int NUM_AXES        = 3;
  localparam int NUM_POINTS      = 4;

  localparam int PARAM_BITS = PARAM_FRAC_BITS + 1;
  localparam int VEL_BITS   = COORD_BITS + 4;
  localparam int CFG_BITS   = NUM_AXES * COORD_BITS;
  localparam int CFG_IDX_BITS = 3;
  localparam int COEF_BITS  = COORD_BITS + 8;
  localparam int ACC_BITS   = COEF_BITS + GUARD_BITS;
  localparam int PROD_BITS  = ACC_BITS + PARAM_BITS + 1;

  localparam int NUM_STAGES = 10;
  localparam int STG_PROD1  = 3;
  localparam int STG_ACC2   = 4;
  localparam int STG_PROD2  = 5;
  localparam int STG_ACC3   = 6;
  localparam int STG_PROD3  = 7;
  localparam int STG_ACC4   = 8;
  localparam int STG_OUT    = 9;

  localparam logic [PARAM_BITS-1:0] T_ONE = PARAM_BITS'(1) << PARAM_FRAC_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CURVE_FORM = 3'd0,
    REG_POINT_A    = 3'd1,
    REG_POINT_B    = 3'd2,
    REG_POINT_C    = 3'd3,
    REG_POINT_D    = 3'd4
  } reg_idx_e;

  typedef enum logic {
    FORM_HERMITE = 1'b0,
    FORM_BEZIER  = 1'b1
  } curve_form_e;

  typedef logic signed [COEF_BITS-1:0] coef_t;
  typedef logic signed [ACC_BITS-1:0]  acc_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;

  typedef struct packed {
    coef_t a;
    coef_t a3;
    coef_t b;
    coef_t b2;
    coef_t c;
    coef_t d;
  } axis_coef_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } stage_ctl_t;

  localparam prod_t PROD_HALF = PROD_BITS'(1) <<< (PARAM_FRAC_BITS - 1);
  localparam acc_t  ACC_HALF  = ACC_BITS'(1) <<< (GUARD_BITS - 1);
  localparam acc_t  POS_HI    = ACC_BITS'((1 <<< (COORD_BITS - 1)) - 1);
  localparam acc_t  POS_LO    = -POS_HI - ACC_BITS'(1);
  localparam acc_t  VEL_HI    = ACC_BITS'((1 <<< (VEL_BITS - 1)) - 1);
  localparam acc_t  VEL_LO    = -VEL_HI - ACC_BITS'(1);

  function automatic acc_t to_guard(input coef_t c);
    return ACC_BITS'(c) <<< GUARD_BITS;
  endfunction

  function automatic acc_t drop_frac(input prod_t p);
    prod_t r;
    r = (p + PROD_HALF) >>> PARAM_FRAC_BITS;
    return r[ACC_BITS-1:0];
  endfunction

  function automatic logic signed [COORD_BITS-1:0] sat_pos(input acc_t acc);
    acc_t r;
    r = (acc + ACC_HALF) >>> GUARD_BITS;
    if (r > POS_HI) begin
      return POS_HI[COORD_BITS-1:0];
    end else if (r < POS_LO) begin
      return POS_LO[COORD_BITS-1:0];
    end
    return r[COORD_BITS-1:0];
  endfunction

  function automatic logic signed [VEL_BITS-1:0] sat_vel(input acc_t acc);
    acc_t r;
    r = (acc + ACC_HALF) >>> GUARD_BITS;
    if (r > VEL_HI) begin
      return VEL_HI[VEL_BITS-1:0];
    end else if (r < VEL_LO) begin
      return VEL_LO[VEL_BITS-1:0];
    end
    return r[VEL_BITS-1:0];
  endfunction

endpackage

/* rtl/csp_cfg.sv */
`timescale 1ns / 1ps

module csp_cfg (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [csp_pkg::CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic [csp_pkg::CFG_BITS-1:0]           cfg_data_i,
  output csp_pkg::axis_coef_t [csp_pkg::NUM_AXES-1:0] coef_o
);
  import csp_pkg::*;

  curve_form_e         form_q;
  logic [CFG_BITS-1:0] pt_q [NUM_POINTS];

  coef_t p0_d [NUM_AXES];
  coef_t p1_d [NUM_AXES];
  coef_t m0_d [NUM_AXES];
  coef_t m1_d [NUM_AXES];
  coef_t p0_q [NUM_AXES];
  coef_t p1_q [NUM_AXES];
  coef_t m0_q [NUM_AXES];
  coef_t m1_q [NUM_AXES];

  axis_coef_t [NUM_AXES-1:0] coef_d;
  axis_coef_t [NUM_AXES-1:0] coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      form_q <= FORM_HERMITE;
      for (int k = 0; k < NUM_POINTS; k++) begin
        pt_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CURVE_FORM: form_q   <= curve_form_e'(cfg_data_i[0]);
        REG_POINT_A:    pt_q[0]  <= cfg_data_i;
        REG_POINT_B:    pt_q[1]  <= cfg_data_i;
        REG_POINT_C:    pt_q[2]  <= cfg_data_i;
        REG_POINT_D:    pt_q[3]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    coef_t q0, q1, q2, q3, d10, d32;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      q0 = COEF_BITS'(signed'(pt_q[0][ax*COORD_BITS +: COORD_BITS]));
      q1 = COEF_BITS'(signed'(pt_q[1][ax*COORD_BITS +: COORD_BITS]));
      q2 = COEF_BITS'(signed'(pt_q[2][ax*COORD_BITS +: COORD_BITS]));
      q3 = COEF_BITS'(signed'(pt_q[3][ax*COORD_BITS +: COORD_BITS]));
      d10 = q1 - q0;
      d32 = q3 - q2;
      p0_d[ax] = q0;
      if (form_q == FORM_BEZIER) begin
        p1_d[ax] = q3;
        m0_d[ax] = d10 + (d10 <<< 1);
        m1_d[ax] = d32 + (d32 <<< 1);
      end else begin
        p1_d[ax] = q1;
        m0_d[ax] = q2;
        m1_d[ax] = q3;
      end
    end
  end

  always_comb begin
    coef_t dp, b;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      dp = p0_q[ax] - p1_q[ax];
      b  = -(dp + (dp <<< 1)) - (m0_q[ax] <<< 1) - m1_q[ax];
      coef_d[ax].a  = (dp <<< 1) + m0_q[ax] + m1_q[ax];
      coef_d[ax].a3 = (dp <<< 2) + (dp <<< 1) + (m0_q[ax] <<< 1) + m0_q[ax]
                      + (m1_q[ax] <<< 1) + m1_q[ax];
      coef_d[ax].b  = b;
      coef_d[ax].b2 = b <<< 1;
      coef_d[ax].c  = m0_q[ax];
      coef_d[ax].d  = p0_q[ax];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        p0_q[ax] <= '0;
        p1_q[ax] <= '0;
        m0_q[ax] <= '0;
        m1_q[ax] <= '0;
      end
      coef_q <= '0;
    end else begin
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        p0_q[ax] <= p0_d[ax];
        p1_q[ax] <= p1_d[ax];
        m0_q[ax] <= m0_d[ax];
        m1_q[ax] <= m1_d[ax];
      end
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

/* rtl/csp_axis.sv */
`timescale 1ns / 1ps

module csp_axis (
  input  logic                                  clk_i,
  input  csp_pkg::stage_ctl_t                   ctl_i,
  input  csp_pkg::axis_coef_t                   coef_i,
  input  logic [csp_pkg::PARAM_BITS-1:0]        t_prod1_i,
  input  logic [csp_pkg::PARAM_BITS-1:0]        t_prod2_i,
  input  logic [csp_pkg::PARAM_BITS-1:0]        t_prod3_i,
  output logic signed [csp_pkg::COORD_BITS-1:0] pos_o,
  output logic signed [csp_pkg::VEL_BITS-1:0]   vel_o
);
  import csp_pkg::*;

  logic signed [PARAM_BITS:0] ts1, ts2, ts3;

  prod_t pprod1_q, vprod1_q, pprod2_q, vprod2_q, pprod3_q;
  acc_t  pacc2_q, vacc2_q, pacc3_q, vacc3_q, pacc4_q;
  logic signed [VEL_BITS-1:0]   vel7_q, vel8_q, vel9_q;
  logic signed [COORD_BITS-1:0] pos9_q;

  assign ts1 = signed'({1'b0, t_prod1_i});
  assign ts2 = signed'({1'b0, t_prod2_i});
  assign ts3 = signed'({1'b0, t_prod3_i});

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[STG_PROD1]) begin
      pprod1_q <= PROD_BITS'(to_guard(coef_i.a)) * PROD_BITS'(ts1);
      vprod1_q <= PROD_BITS'(to_guard(coef_i.a3)) * PROD_BITS'(ts1);
    end
    if (ctl_i.load[STG_ACC2]) begin
      pacc2_q <= drop_frac(pprod1_q) + to_guard(coef_i.b);
      vacc2_q <= drop_frac(vprod1_q) + to_guard(coef_i.b2);
    end
    if (ctl_i.load[STG_PROD2]) begin
      pprod2_q <= PROD_BITS'(pacc2_q) * PROD_BITS'(ts2);
      vprod2_q <= PROD_BITS'(vacc2_q) * PROD_BITS'(ts2);
    end
    if (ctl_i.load[STG_ACC3]) begin
      pacc3_q <= drop_frac(pprod2_q) + to_guard(coef_i.c);
      vacc3_q <= drop_frac(vprod2_q) + to_guard(coef_i.c);
    end
    if (ctl_i.load[STG_PROD3]) begin
      pprod3_q <= PROD_BITS'(pacc3_q) * PROD_BITS'(ts3);
      vel7_q   <= sat_vel(vacc3_q);
    end
    if (ctl_i.load[STG_ACC4]) begin
      pacc4_q <= drop_frac(pprod3_q) + to_guard(coef_i.d);
      vel8_q  <= vel7_q;
    end
    if (ctl_i.load[STG_OUT]) begin
      pos9_q <= sat_pos(pacc4_q);
      vel9_q <= vel8_q;
    end
  end

  assign pos_o = pos9_q;
  assign vel_o = vel9_q;

endmodule

/* rtl/cubic_spline_point_evaluator.sv */
`timescale 1ns / 1ps

// Evaluates a cubic Hermite or Bezier curve, set by four configured 3D points,
// at one parameter t per transaction: one transaction per cycle sustained
// while the output is not stalled; each result comes from a ten-stage
// pipeline whose input stage loads at the accepting edge: an input and two
// wait stages, then the three Horner multiply-by-t steps of the position,
// each followed by a round-and-add stage, and the saturating output register.
// The velocity chain runs beside it on its own multipliers. Coefficients are
// recomputed from the registers through the point-and-tangent registers and
// then the coefficient register, covered by the two wait stages, so a
// configuration write applies to every transaction accepted at the same edge
// or later. Stalls hold each stage in place while empty stages keep filling.
module cubic_spline_point_evaluator (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [csp_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [csp_pkg::CFG_BITS-1:0]          cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [csp_pkg::PARAM_BITS-1:0]        curve_param_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [csp_pkg::COORD_BITS-1:0] pos_x_o,
  output logic signed [csp_pkg::COORD_BITS-1:0] pos_y_o,
  output logic signed [csp_pkg::COORD_BITS-1:0] pos_z_o,
  output logic signed [csp_pkg::VEL_BITS-1:0]   vel_x_o,
  output logic signed [csp_pkg::VEL_BITS-1:0]   vel_y_o,
  output logic signed [csp_pkg::VEL_BITS-1:0]   vel_z_o
);
  import csp_pkg::*;

  axis_coef_t [NUM_AXES-1:0] coef;
  stage_ctl_t                ctl;

  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] valid_in;
  logic [NUM_STAGES-1:0] ready;

  logic [PARAM_BITS-1:0] t_clamp;
  logic [PARAM_BITS-1:0] t_in [STG_PROD3];
  logic [PARAM_BITS-1:0] t_q  [STG_PROD3];

  logic signed [COORD_BITS-1:0] pos [NUM_AXES];
  logic signed [VEL_BITS-1:0]   vel [NUM_AXES];

  csp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .coef_o     (coef)
  );

  assign valid_in = {valid_q[NUM_STAGES-2:0], in_valid_i};

  always_comb begin
    ready[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || !out_stall_i;
    for (int s = NUM_STAGES - 2; s >= 0; s--) begin
      ready[s] = !valid_q[s] || ready[s+1];
    end
  end

  assign ctl.load = valid_in & ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int s = 0; s < NUM_STAGES; s++) begin
        if (ready[s]) begin
          valid_q[s] <= valid_in[s];
        end
      end
    end
  end

  assign t_clamp = (curve_param_i > T_ONE) ? T_ONE : curve_param_i;

  always_comb begin
    t_in[0] = t_clamp;
    for (int s = 1; s < STG_PROD3; s++) begin
      t_in[s] = t_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < STG_PROD3; s++) begin
      if (ctl.load[s]) begin
        t_q[s] <= t_in[s];
      end
    end
  end

  for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_axis
    csp_axis u_axis (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .coef_i    (coef[ax]),
      .t_prod1_i (t_q[STG_PROD1-1]),
      .t_prod2_i (t_q[STG_PROD2-1]),
      .t_prod3_i (t_q[STG_PROD3-1]),
      .pos_o     (pos[ax]),
      .vel_o     (vel[ax])
    );
  end

  assign in_stall_o  = !ready[0];
  assign out_valid_o = valid_q[STG_OUT];
  assign pos_x_o     = pos[0];
  assign pos_y_o     = pos[1];
  assign pos_z_o     = pos[2];
  assign vel_x_o     = vel[0];
  assign vel_y_o     = vel[1];
  assign vel_z_o     = vel[2];

endmodule

/* rtl/csp_checker.sv */
`timescale 1ns / 1ps

module csp_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic signed [csp_pkg::COORD_BITS-1:0] pos_x_o,
  input logic signed [csp_pkg::COORD_BITS-1:0] pos_y_o,
  input logic signed [csp_pkg::COORD_BITS-1:0] pos_z_o,
  input logic signed [csp_pkg::VEL_BITS-1:0]   vel_x_o,
  input logic signed [csp_pkg::VEL_BITS-1:0]   vel_y_o,
  input logic signed [csp_pkg::VEL_BITS-1:0]   vel_z_o
);
  import csp_pkg::*;

  localparam int CNT_BITS = $clog2(NUM_STAGES + 1);

  logic                in_acc;
  logic                out_acc;
  logic [CNT_BITS-1:0] pending_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + CNT_BITS'(in_acc) - CNT_BITS'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pos_x_o) && $stable(pos_y_o) && $stable(pos_z_o)
      && $stable(vel_x_o) && $stable(vel_y_o) && $stable(vel_z_o))
    else $error("stalled result changed");

  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output stage");

  a_no_extra_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != '0)
    else $error("result without accepted transaction");

endmodule

bind cubic_spline_point_evaluator csp_checker u_checker (.*);

/* dv/cubic_spline_point_evaluator_checker.sv */
`timescale 1ns / 1ps

module cubic_spline_point_evaluator_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [csp_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [csp_pkg::CFG_BITS-1:0]          cfg_data_i,
  input  logic                                  in_valid_i,
  input  logic                                  in_stall_i,
  input  logic [csp_pkg::PARAM_BITS-1:0]        curve_param_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_stall_i,
  input  logic signed [csp_pkg::COORD_BITS-1:0] pos_x_i,
  input  logic signed [csp_pkg::COORD_BITS-1:0] pos_y_i,
  input  logic signed [csp_pkg::COORD_BITS-1:0] pos_z_i,
  input  logic signed [csp_pkg::VEL_BITS-1:0]   vel_x_i,
  input  logic signed [csp_pkg::VEL_BITS-1:0]   vel_y_i,
  input  logic signed [csp_pkg::VEL_BITS-1:0]   vel_z_i,
  output int                                    mismatches_o,
  output int                                    pending_o
);

  import csp_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [PARAM_BITS-1:0]        t;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic signed [VEL_BITS-1:0]   vel_x;
    logic signed [VEL_BITS-1:0]   vel_y;
    logic signed [VEL_BITS-1:0]   vel_z;
  } curve_sample_t;

  curve_form_e          form_r = FORM_HERMITE;
  logic [CFG_BITS-1:0]  point_r [NUM_POINTS] = '{default: '0};
  curve_sample_t        awaited_samples_q [$];
  int                   mismatch_count = 0;
  int                   awaited_count = 0;

  assign mismatches_o = mismatch_count;
  assign pending_o    = awaited_count;

  function automatic longint coord_of(input logic [CFG_BITS-1:0] pt, input int axis);
    logic signed [COORD_BITS-1:0] v;
    v = pt[axis*COORD_BITS +: COORD_BITS];
    return longint'(v);
  endfunction

  // round half up, i.e. floor((x + half) / 2^n)
  function automatic longint rnd_shift(input longint x, input int n);
    return (x + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp_to(input longint v, input int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic void eval_axis(input int axis, input longint t,
                                    output longint pos, output longint vel);
    longint q [NUM_POINTS];
    longint p0, p1, m0, m1, a, b, c, acc, g;
    for (int i = 0; i < NUM_POINTS; i++) q[i] = coord_of(point_r[i], axis);
    g = longint'(1) <<< GUARD_BITS;
    if (form_r == FORM_BEZIER) begin
      p0 = q[0];
      p1 = q[3];
      m0 = 3 * (q[1] - q[0]);
      m1 = 3 * (q[3] - q[2]);
    end else begin
      p0 = q[0];
      p1 = q[1];
      m0 = q[2];
      m1 = q[3];
    end
    a = 2 * (p0 - p1) + m0 + m1;
    b = -3 * (p0 - p1) - 2 * m0 - m1;
    c = m0;

    acc = a * g;
    acc = rnd_shift(acc * t, PARAM_FRAC_BITS) + b * g;
    acc = rnd_shift(acc * t, PARAM_FRAC_BITS) + c * g;
    acc = rnd_shift(acc * t, PARAM_FRAC_BITS) + p0 * g;
    pos = clamp_to(rnd_shift(acc, GUARD_BITS), COORD_BITS);

    acc = 3 * a * g;
    acc = rnd_shift(acc * t, PARAM_FRAC_BITS) + 2 * b * g;
    acc = rnd_shift(acc * t, PARAM_FRAC_BITS) + c * g;
    vel = clamp_to(rnd_shift(acc, GUARD_BITS), VEL_BITS);
  endfunction

  function automatic curve_sample_t predict_sample(input logic [PARAM_BITS-1:0] raw_t);
    curve_sample_t s;
    longint t;
    longint p [NUM_AXES];
    longint v [NUM_AXES];
    // clamp t above one
    t = (raw_t > T_ONE) ? longint'(T_ONE) : longint'(raw_t);
    for (int axis = 0; axis < NUM_AXES; axis++) eval_axis(axis, t, p[axis], v[axis]);
    s.t     = raw_t;
    s.pos_x = COORD_BITS'(p[0]);
    s.pos_y = COORD_BITS'(p[1]);
    s.pos_z = COORD_BITS'(p[2]);
    s.vel_x = VEL_BITS'(v[0]);
    s.vel_y = VEL_BITS'(v[1]);
    s.vel_z = VEL_BITS'(v[2]);
    return s;
  endfunction

  task automatic note_mismatch(input string field, input longint t, input longint want,
                               input longint got);
    if (mismatch_count < MAX_REPORTS) begin
      $display("%0t: %s mismatch at t=%0d: expected %0d, got %0d", $realtime, field, t,
               want, got);
    end
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    curve_sample_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CURVE_FORM: form_r = curve_form_e'(cfg_data_i[0]);
          REG_POINT_A, REG_POINT_B, REG_POINT_C, REG_POINT_D: begin
            point_r[int'(cfg_idx_i) - int'(REG_POINT_A)] = cfg_data_i;
          end
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        if (awaited_samples_q.size() == 0) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("%0t: result transaction with none expected", $realtime);
          end
          mismatch_count++;
        end else begin
          want = awaited_samples_q.pop_front();
          if (pos_x_i !== want.pos_x) note_mismatch("pos_x", want.t, want.pos_x, pos_x_i);
          if (pos_y_i !== want.pos_y) note_mismatch("pos_y", want.t, want.pos_y, pos_y_i);
          if (pos_z_i !== want.pos_z) note_mismatch("pos_z", want.t, want.pos_z, pos_z_i);
          if (vel_x_i !== want.vel_x) note_mismatch("vel_x", want.t, want.vel_x, vel_x_i);
          if (vel_y_i !== want.vel_y) note_mismatch("vel_y", want.t, want.vel_y, vel_y_i);
          if (vel_z_i !== want.vel_z) note_mismatch("vel_z", want.t, want.vel_z, vel_z_i);
        end
      end

      if (in_valid_i && !in_stall_i) awaited_samples_q.push_back(predict_sample(curve_param_i));
      awaited_count = awaited_samples_q.size();
    end
  end

endmodule

/* dv/cubic_spline_point_evaluator_tb.sv */
`timescale 1ns / 1ps

module cubic_spline_point_evaluator_tb;

  import csp_pkg::*;

  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int NUM_CORNERS     = 8;

  typedef enum int {
    STYLE_SMALL,
    STYLE_FULL,
    STYLE_EXTREME,
    STYLE_MIXED
  } point_style_e;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we;
  logic [CFG_IDX_BITS-1:0]      cfg_idx;
  logic [CFG_BITS-1:0]          cfg_data;
  logic                         in_valid;
  logic                         in_stall;
  logic [PARAM_BITS-1:0]        curve_param;
  logic                         out_valid;
  logic                         out_stall;
  logic signed [COORD_BITS-1:0] pos_x, pos_y, pos_z;
  logic signed [VEL_BITS-1:0]   vel_x, vel_y, vel_z;
  int                           mismatches;
  int                           pending;

  bit                           calm = 1'b0;
  int                           n_sent = 0;
  int                           n_curves = 0;
  int                           n_bezier = 0;
  logic [PARAM_BITS-1:0]        corner_params [NUM_CORNERS];

  cubic_spline_point_evaluator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .curve_param_i (curve_param),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .pos_x_o       (pos_x),
    .pos_y_o       (pos_y),
    .pos_z_o       (pos_z),
    .vel_x_o       (vel_x),
    .vel_y_o       (vel_y),
    .vel_z_o       (vel_z)
  );

  cubic_spline_point_evaluator_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .curve_param_i (curve_param),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .pos_x_i       (pos_x),
    .pos_y_i       (pos_y),
    .pos_z_i       (pos_z),
    .vel_x_i       (vel_x),
    .vel_y_i       (vel_y),
    .vel_z_i       (vel_z),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("cubic_spline_point_evaluator_tb NOT OK");
    $finish;
  end

  // receiver backpressure in short bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 6) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
        out_stall = 1'b0;
      end
    end
  end

  function automatic logic [COORD_BITS-1:0] random_coord(input point_style_e style);
    point_style_e mode;
    mode = (style == STYLE_MIXED) ? point_style_e'($urandom_range(0, 2)) : style;
    case (mode)
      STYLE_SMALL: return COORD_BITS'($urandom_range(0, 800)) - COORD_BITS'(400);
      STYLE_FULL:  return COORD_BITS'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0:       return {1'b0, {(COORD_BITS-1){1'b1}}};
          1:       return {1'b1, {(COORD_BITS-1){1'b0}}};
          2:       return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  function automatic logic [CFG_BITS-1:0] random_point(input point_style_e style);
    logic [CFG_BITS-1:0] pt;
    for (int axis = 0; axis < NUM_AXES; axis++) begin
      pt[axis*COORD_BITS +: COORD_BITS] = random_coord(style);
    end
    return pt;
  endfunction

  function automatic logic [PARAM_BITS-1:0] next_param();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return T_ONE;
      2:       return PARAM_BITS'($urandom_range(int'(T_ONE) + 1, (1 << PARAM_BITS) - 1));
      3:       return PARAM_BITS'($urandom_range(0, 15));
      default: return PARAM_BITS'($urandom_range(0, int'(T_ONE)));
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_BITS-1:0] data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk_i);
  endtask

  // write every register, unused indexes first; block must be idle
  task automatic apply_curve(input curve_form_e form, input logic [CFG_BITS-1:0] pa,
                             input logic [CFG_BITS-1:0] pb, input logic [CFG_BITS-1:0] pc,
                             input logic [CFG_BITS-1:0] pd);
    logic [CFG_BITS-1:0] form_word;
    for (int i = int'(REG_POINT_D) + 1; i < (1 << CFG_IDX_BITS); i++) begin
      write_reg(CFG_IDX_BITS'(i), CFG_BITS'({$urandom, $urandom}));
    end
    form_word    = CFG_BITS'({$urandom, $urandom});
    form_word[0] = form;
    write_reg(REG_CURVE_FORM, form_word);
    write_reg(REG_POINT_A, pa);
    write_reg(REG_POINT_B, pb);
    write_reg(REG_POINT_C, pc);
    write_reg(REG_POINT_D, pd);
    cfg_we = 1'b0;
    n_curves++;
    if (form == FORM_BEZIER) n_bezier++;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic send_param(input logic [PARAM_BITS-1:0] t);
    curve_param = t;
    in_valid    = 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    n_sent++;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid    = 1'b0;
      curve_param = PARAM_BITS'($urandom);
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
  endtask

  task automatic send_corners(input int first, input int count);
    for (int i = first; i < first + count; i++) send_param(corner_params[i]);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = REG_CURVE_FORM;
    cfg_data      = '0;
    in_valid      = 1'b0;
    curve_param   = '0;
    corner_params = '{16'h0000, T_ONE, 16'hFFFF, 16'h4000, 16'h7FFF, 16'h8001,
                      16'h0001, 16'hC000};
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // registers at reset
    send_corners(0, 3);

    drain();
    apply_curve(FORM_HERMITE, random_point(STYLE_SMALL), random_point(STYLE_SMALL),
                random_point(STYLE_SMALL), random_point(STYLE_SMALL));
    send_corners(0, NUM_CORNERS);

    // full-scale end points of opposite sign on every axis
    drain();
    apply_curve(FORM_HERMITE, {16'h7FFF, 16'h8000, 16'h7FFF},
                {16'h8000, 16'h7FFF, 16'h8000}, {16'h7FFF, 16'h8000, 16'h0000},
                {16'h7FFF, 16'h8000, 16'hFFFF});
    send_corners(0, 4);

    drain();
    apply_curve(FORM_BEZIER, {3{16'h8000}}, {3{16'h7FFF}}, {3{16'h8000}}, {3{16'h7FFF}});
    send_corners(0, 4);

    drain();
    apply_curve(FORM_BEZIER, random_point(STYLE_FULL), random_point(STYLE_FULL),
                random_point(STYLE_FULL), random_point(STYLE_FULL));
    send_corners(4, 3);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      point_style_e style;
      curve_form_e  form;
      style = point_style_e'(ph % (int'(STYLE_MIXED) + 1));
      form  = curve_form_e'($urandom_range(0, 1));
      drain();
      calm = (ph >= RANDOM_PHASES - 2) || ($urandom_range(0, 3) == 0);
      apply_curve(form, random_point(style), random_point(style), random_point(style),
                  random_point(style));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // hold off mid-phase until the pipeline is empty
        if (ph == 3 && i == ITEMS_PER_PHASE / 2) drain();
        send_param(next_param());
      end
    end

    drain();
    repeat (2 * NUM_STAGES) @(negedge clk_i);
    $display("Sent %0d parameter samples through %0d curve settings (%0d Bezier),",
             n_sent, n_curves, n_bezier);
    $display("including saturating corners, t above one and junk register bits.");
    if (mismatches == 0 && pending == 0) begin
      $display("cubic_spline_point_evaluator_tb OK");
    end else begin
      $display("cubic_spline_point_evaluator_tb NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/csp_pkg.sv
rtl/csp_cfg.sv
rtl/csp_axis.sv
rtl/cubic_spline_point_evaluator.sv
rtl/csp_checker.sv
dv/cubic_spline_point_evaluator_checker.sv
dv/cubic_spline_point_evaluator_tb.sv
